/* rtl/core/xml_entity_decoder_assert.svh */
// Assertion macros shared by the XML entity decoder modules.
// Each macro expands to one labeled concurrent assertion that reports with $error.
`ifndef XML_ENTITY_DECODER_ASSERT_SVH
`define XML_ENTITY_DECODER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define XED_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define XED_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/xed_pkg.sv */
// Package for the XML entity decoder: payload and queue entry types, scan modes,
// character constants and the entity spelling tables. No dependencies.
`timescale 1ns / 1ps

package xed_pkg;

   localparam int unsigned PendDepth  = 5;
   localparam int unsigned MaxResults = 6;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned CountWidth = $clog2(MaxResults + 1);

   // Positions inside the pending buffer.
   localparam int unsigned PosFirst = 1;
   localparam int unsigned PosX     = 2;
   localparam int unsigned PosHi    = 3;
   localparam int unsigned PosLo    = 4;

   localparam logic [7:0] CharAmp  = 8'h26;
   localparam logic [7:0] CharHash = 8'h23;
   localparam logic [7:0] CharSemi = 8'h3B;
   localparam logic [7:0] CharX    = 8'h78;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_AMP,
      MODE_NAMED,
      MODE_NUM
   } scan_mode_type;

   typedef enum logic [1:0] {
      ENT_AMP,
      ENT_LT,
      ENT_GT,
      ENT_QUOT
   } entity_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       bad_reference;
      logic       out_last;
   } rsp_type;

   // Everything one input beat produces, in output order.
   typedef struct packed {
      logic [MaxResults-1:0][7:0]  bytes;
      logic [MaxResults-1:0]       bad;
      logic [CountWidth-1:0]       count;
      logic                        last;
   } entry_type;

   function automatic logic [7:0] to_lower(logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   function automatic logic is_hex(logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
   endfunction

   function automatic logic [3:0] hex_nibble(logic [7:0] b);
      logic [7:0] v;
      if (b >= "0" && b <= "9") begin
         v = b - "0";
      end else if (b >= "A" && b <= "F") begin
         v = b - "A" + 8'd10;
      end else begin
         v = b - "a" + 8'd10;
      end
      return v[3:0];
   endfunction

   // Character expected at a given buffer position of a named entity; zero past its end.
   function automatic logic [7:0] entity_char(entity_type choice, logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (choice)
         ENT_AMP: begin
            case (idx)
               3'd0: c = CharAmp;
               3'd1: c = "a";
               3'd2: c = "m";
               3'd3: c = "p";
               3'd4: c = CharSemi;
               default: c = 8'h00;
            endcase
         end
         ENT_LT: begin
            case (idx)
               3'd0: c = CharAmp;
               3'd1: c = "l";
               3'd2: c = "t";
               3'd3: c = CharSemi;
               default: c = 8'h00;
            endcase
         end
         ENT_GT: begin
            case (idx)
               3'd0: c = CharAmp;
               3'd1: c = "g";
               3'd2: c = "t";
               3'd3: c = CharSemi;
               default: c = 8'h00;
            endcase
         end
         ENT_QUOT: begin
            case (idx)
               3'd0: c = CharAmp;
               3'd1: c = "q";
               3'd2: c = "u";
               3'd3: c = "o";
               3'd4: c = "t";
               3'd5: c = CharSemi;
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] entity_symbol(entity_type choice);
      logic [7:0] s;
      case (choice)
         ENT_AMP:  s = "&";
         ENT_LT:   s = "<";
         ENT_GT:   s = ">";
         ENT_QUOT: s = 8'h22;
         default:  s = "&";
      endcase
      return s;
   endfunction

endpackage

/* rtl/core/xed_front.sv */
// Front end of the XML entity decoder: accepts input beats, tracks the open
// reference and turns each beat that yields results into one queue entry. Depends on xed_pkg.
`timescale 1ns / 1ps

`include "xml_entity_decoder_assert.svh"

module xed_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  xed_pkg::req_type     req_data,
   input  logic                 queue_full,
   output logic                 push_valid,
   output xed_pkg::entry_type   push_entry
);

   xed_pkg::scan_mode_type mode_ff, mode_in;
   xed_pkg::entity_type    choice_ff, choice_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [7:0]             pend_ff [xed_pkg::PendDepth];
   logic [7:0]             pend_in [xed_pkg::PendDepth];

   logic                   accept;
   logic [7:0]             b;
   logic [7:0]             lb;
   logic                   last;
   logic [7:0]             want;
   logic                   push;
   logic                   fail;
   logic                   done;
   logic [7:0]             done_byte;
   xed_pkg::scan_mode_type push_mode;
   xed_pkg::entity_type    push_choice;
   logic                   take;
   logic                   tail_v;
   logic [7:0]             tail_byte;
   logic                   tail_bad;
   logic                   rep_v;
   logic                   rep_num;
   logic [2:0]             rep_hi;
   logic [2:0]             rep_n;
   logic [7:0]             post [xed_pkg::PendDepth];
   logic [7:0]             rep_src [xed_pkg::PendDepth];
   logic [7:0]             rep_shift [xed_pkg::PendDepth];

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      b           = req_data.in_byte;
      last        = req_data.in_last;
      lb          = xed_pkg::to_lower(b);
      want        = xed_pkg::entity_char(choice_ff, cnt_ff);
      push        = 1'b0;
      fail        = 1'b0;
      done        = 1'b0;
      done_byte   = b;
      push_mode   = mode_ff;
      push_choice = choice_ff;

      case (mode_ff)
         xed_pkg::MODE_IDLE: begin
            push = 1'b0;
         end
         xed_pkg::MODE_AMP: begin
            if (b == xed_pkg::CharHash) begin
               push      = 1'b1;
               push_mode = xed_pkg::MODE_NUM;
            end else if (lb == xed_pkg::entity_char(xed_pkg::ENT_AMP, 3'(xed_pkg::PosFirst))) begin
               push        = 1'b1;
               push_mode   = xed_pkg::MODE_NAMED;
               push_choice = xed_pkg::ENT_AMP;
            end else if (lb == xed_pkg::entity_char(xed_pkg::ENT_LT, 3'(xed_pkg::PosFirst))) begin
               push        = 1'b1;
               push_mode   = xed_pkg::MODE_NAMED;
               push_choice = xed_pkg::ENT_LT;
            end else if (lb == xed_pkg::entity_char(xed_pkg::ENT_GT, 3'(xed_pkg::PosFirst))) begin
               push        = 1'b1;
               push_mode   = xed_pkg::MODE_NAMED;
               push_choice = xed_pkg::ENT_GT;
            end else if (lb == xed_pkg::entity_char(xed_pkg::ENT_QUOT,
                                                    3'(xed_pkg::PosFirst))) begin
               push        = 1'b1;
               push_mode   = xed_pkg::MODE_NAMED;
               push_choice = xed_pkg::ENT_QUOT;
            end else begin
               fail = 1'b1;
            end
         end
         xed_pkg::MODE_NAMED: begin
            if (want != 8'h00 && lb == want) begin
               if (want == xed_pkg::CharSemi) begin
                  done      = 1'b1;
                  done_byte = xed_pkg::entity_symbol(choice_ff);
               end else if (cnt_ff < 3'(xed_pkg::PendDepth)) begin
                  push = 1'b1;
               end else begin
                  fail = 1'b1;
               end
            end else begin
               fail = 1'b1;
            end
         end
         xed_pkg::MODE_NUM: begin
            case (cnt_ff)
               3'(xed_pkg::PosX): begin
                  if (b == xed_pkg::CharX) begin
                     push = 1'b1;
                  end else begin
                     fail = 1'b1;
                  end
               end
               3'(xed_pkg::PosHi): begin
                  if (xed_pkg::is_hex(b)) begin
                     push = 1'b1;
                  end else begin
                     fail = 1'b1;
                  end
               end
               3'(xed_pkg::PosLo): begin
                  if (xed_pkg::is_hex(b)) begin
                     push = 1'b1;
                  end else if (b == xed_pkg::CharSemi) begin
                     done      = 1'b1;
                     done_byte = {4'h0, xed_pkg::hex_nibble(pend_ff[xed_pkg::PosHi])};
                  end else begin
                     fail = 1'b1;
                  end
               end
               3'(xed_pkg::PendDepth): begin
                  if (b == xed_pkg::CharSemi) begin
                     done      = 1'b1;
                     done_byte = {xed_pkg::hex_nibble(pend_ff[xed_pkg::PosHi]),
                                  xed_pkg::hex_nibble(pend_ff[xed_pkg::PosLo])};
                  end else begin
                     fail = 1'b1;
                  end
               end
               default: fail = 1'b1;
            endcase
         end
         default: fail = 1'b1;
      endcase

      // A byte that breaks a match is handled as if the block were idle.
      take = (mode_ff == xed_pkg::MODE_IDLE) || fail;

      tail_v    = 1'b0;
      tail_byte = b;
      tail_bad  = 1'b0;
      if (done) begin
         tail_v    = 1'b1;
         tail_byte = done_byte;
      end else if (take) begin
         if (b == xed_pkg::CharAmp) begin
            // A fresh '&' on the final beat is flushed at once as a failed reference.
            tail_v   = last;
            tail_bad = 1'b1;
         end else begin
            tail_v = 1'b1;
         end
      end

      post = pend_ff;
      if (push) begin
         post[cnt_ff] = b;
      end

      // Replay either the old buffer on a failure or the updated one on a final beat.
      rep_v = fail || (push && last);
      if (fail) begin
         rep_src = pend_ff;
         rep_num = (mode_ff == xed_pkg::MODE_NUM);
         rep_hi  = cnt_ff;
      end else begin
         rep_src = post;
         rep_num = (push_mode == xed_pkg::MODE_NUM);
         rep_hi  = cnt_ff + 3'd1;
      end
      rep_n = rep_v ? (rep_hi - {2'b00, rep_num}) : 3'd0;

      // A numeric reference drops its leading '&'.
      for (int i = 0; i < xed_pkg::PendDepth; i++) begin
         rep_shift[i] = rep_src[i];
      end
      if (rep_num) begin
         for (int i = 0; i < xed_pkg::PendDepth - 1; i++) begin
            rep_shift[i] = rep_src[i + 1];
         end
      end

      for (int i = 0; i < xed_pkg::MaxResults; i++) begin
         if (i < xed_pkg::PendDepth && 3'(i) < rep_n) begin
            push_entry.bytes[i] = rep_shift[i % xed_pkg::PendDepth];
            push_entry.bad[i]   = 1'b1;
         end else begin
            push_entry.bytes[i] = tail_byte;
            push_entry.bad[i]   = tail_bad;
         end
      end
      push_entry.count = xed_pkg::CountWidth'(rep_n) + xed_pkg::CountWidth'(tail_v);
      push_entry.last  = last;
      push_valid       = accept && (push_entry.count != '0);

      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      choice_in = choice_ff;
      pend_in   = pend_ff;
      if (accept) begin
         if (done) begin
            mode_in = xed_pkg::MODE_IDLE;
            cnt_in  = 3'd0;
         end else if (take) begin
            if (b == xed_pkg::CharAmp && !last) begin
               mode_in    = xed_pkg::MODE_AMP;
               cnt_in     = 3'd1;
               pend_in[0] = b;
            end else begin
               mode_in = xed_pkg::MODE_IDLE;
               cnt_in  = 3'd0;
            end
         end else if (push) begin
            pend_in   = post;
            choice_in = push_choice;
            if (last) begin
               mode_in = xed_pkg::MODE_IDLE;
               cnt_in  = 3'd0;
            end else begin
               mode_in = push_mode;
               cnt_in  = cnt_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= xed_pkg::MODE_IDLE;
         cnt_ff    <= 3'd0;
         choice_ff <= xed_pkg::ENT_AMP;
      end else begin
         mode_ff   <= mode_in;
         cnt_ff    <= cnt_in;
         choice_ff <= choice_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   `XED_ASSERT_ALWAYS(a_idle_empty, clock, reset,
      (mode_ff == xed_pkg::MODE_IDLE) == (cnt_ff == 3'd0), "idle mode and buffer fill disagree")
   `XED_ASSERT_ALWAYS(a_cnt_range, clock, reset,
      cnt_ff <= 3'(xed_pkg::PendDepth), "pending buffer overfilled")

endmodule

/* rtl/core/xed_queue.sv */
// Short queue of decoded entries between the front and back ends of the
// XML entity decoder. Depends on xed_pkg.
`timescale 1ns / 1ps

`include "xml_entity_decoder_assert.svh"

module xed_queue #(
   parameter int unsigned DEPTH = xed_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  xed_pkg::entry_type   push_entry,
   output logic                 full,
   output logic                 head_valid,
   output xed_pkg::entry_type   head_entry,
   input  logic                 pop
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   xed_pkg::entry_type entry_ff [DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_pop;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `XED_ASSERT_IMPLIES(a_no_overflow, clock, reset, push_valid, !full,
      "entry pushed into a full queue")
   `XED_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CntW'(DEPTH),
      "queue count out of range")

endmodule

/* rtl/core/xed_back.sv */
// Back end of the XML entity decoder: walks the head queue entry one result beat per cycle,
// while the output is not stalled, into the output register. Depends on xed_pkg.
`timescale 1ns / 1ps

`include "xml_entity_decoder_assert.svh"

module xed_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  xed_pkg::entry_type   head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output xed_pkg::rsp_type     rsp_data
);

   logic [xed_pkg::CountWidth-1:0] pos_ff, pos_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   xed_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic                           load;
   logic                           at_end;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      // The output register takes a new beat when it is empty or being drained.
      load   = head_valid && (!rsp_valid_ff || !rsp_stall);
      at_end = (pos_ff == head_entry.count - 1'b1);
      pop    = load && at_end;

      rsp_data_in.out_byte      = head_entry.bytes[pos_ff];
      rsp_data_in.bad_reference = head_entry.bad[pos_ff];
      rsp_data_in.out_last      = head_entry.last && at_end;

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

      pos_in = pos_ff;
      if (load) begin
         pos_in = at_end ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `XED_ASSERT_IMPLIES(a_pos_in_entry, clock, reset, head_valid, pos_ff < head_entry.count,
      "result position beyond head entry")

endmodule

/* rtl/core/xml_entity_decoder.sv */
// XML entity decoder: one input byte accepted per cycle while the queue is not full; one
// decoded byte delivered per cycle while the output is not stalled. A beat's first result
// passes through the queue entry register and then the output register. A beat yields up
// to six results (a failed reference's bytes plus the breaking byte); the two-entry queue takes
// one more beat, then the input stalls until they drain. Result stalls back up the same way.
// Reset (synchronous, active high) closes any open reference and empties queue and output.
`timescale 1ns / 1ps

module xml_entity_decoder #(
   parameter int unsigned QUEUE_DEPTH = xed_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  xed_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output xed_pkg::rsp_type   rsp_data
);

   logic               push_valid;
   xed_pkg::entry_type push_entry;
   logic               queue_full;
   logic               head_valid;
   xed_pkg::entry_type head_entry;
   logic               pop;

   xed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   xed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   xed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
